### src/ttt_pkg.sv
`default_nettype none

package ttt_pkg;

    // Default sizes
    localparam int CHANNELS_DEF        = 13;
    localparam int MAX_CAL_SAMPLES_DEF = 255;

    // Field widths
    localparam int OP_W     = 3;
    localparam int CHAN_W   = 4;
    localparam int RAW_W    = 16;
    localparam int TIME_W   = 32;
    localparam int SUM_W    = 24;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W   = 5;

    // Configuration reset values
    localparam logic [RAW_W-1:0]  TOUCH_OFFSET_RST  = 16'd100;
    localparam logic [RAW_W-1:0]  DEBOUNCE_TIME_RST = 16'd150;
    localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST  = 32'd600000;

    // Input opcodes
    typedef enum logic [OP_W-1:0] {
        OP_DETECT    = 3'd0,
        OP_CAL_START = 3'd1,
        OP_CAL_SAMPLE = 3'd2,
        OP_CAL_FINISH = 3'd3,
        OP_LOAD_THR  = 3'd4
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOUCH_OFFSET  = 2'd0,
        REG_DEBOUNCE_TIME = 2'd1,
        REG_IDLE_TIMEOUT  = 2'd2
    } cfg_reg_t;

    // Result kinds
    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_CAL_END = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FRAME,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_STORE,
        ST_CAL_DONE
    } state_t;

endpackage

`default_nettype wire

### src/touch_threshold_trigger_top.sv
`default_nettype none
// Multi-channel touch detector.
// Input channel (in_valid / in_stall): one transaction per channel sample,
// calibration command or threshold load. The block raises in_stall while it
// works on a transaction and drops it when back in idle.
// Output channel (out_valid / out_stall): a frame result on a detect sample
// marked frame_end, and a calibration-finished result on finish calibration.
// Results sit in an output register; a new transaction is taken while a
// result waits, and only a transaction that makes a result waits for it.
// Steps per transaction, after the accept in idle:
//   detect sample without frame end, calibration commands, threshold load: execute
//   detect sample with frame end: execute, then frame, held while the output stalls
//   finish calibration: per channel a load, 24 divider steps and a store, then
//   calibration done, held while the output stalls; each channel runs through a
//   single shared restoring divider, one quotient bit per cycle.
// Configuration is written through cfg_write_en / cfg_index / cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Reset (rst_n low, asynchronous) clears thresholds, flags, trigger times,
// calibration sums and counts, the idle timer and the output valid, and
// loads the configuration defaults.
module touch_threshold_trigger_top
    import ttt_pkg::*;
#(
    parameter int CHANNELS        = CHANNELS_DEF,
    parameter int MAX_CAL_SAMPLES = MAX_CAL_SAMPLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [OP_W-1:0]       opcode,
    input  wire logic [CHAN_W-1:0]     channel,
    input  wire logic [RAW_W-1:0]      raw_value,
    input  wire logic [TIME_W-1:0]     now_ms,
    input  wire logic                  frame_end,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       result_kind,
    output logic                       trigger_valid,
    output logic [CHAN_W-1:0]          trigger_channel,
    output logic                       enter_ambient
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0]    LAST_CH  = CH_W'(CHANNELS - 1);
    localparam logic [STEP_W-1:0]  DIV_LAST = STEP_W'(SUM_W - 1);
    localparam logic [COUNT_W-1:0] CAL_MAX  = COUNT_W'(MAX_CAL_SAMPLES);

    // Configuration registers
    logic [RAW_W-1:0]  touch_offset_reg;
    logic [RAW_W-1:0]  debounce_time_reg;
    logic [TIME_W-1:0] idle_timeout_reg;

    // Per-channel state
    logic [RAW_W-1:0]   thr_reg   [CHANNELS];
    logic               above_reg [CHANNELS];
    logic [TIME_W-1:0]  trig_reg  [CHANNELS];
    logic [SUM_W-1:0]   sum_reg   [CHANNELS];
    logic [COUNT_W-1:0] cnt_reg   [CHANNELS];

    // Sequencer and transaction registers
    state_t             state_reg, state_next;
    opcode_t            op_reg, op_next;
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic               fend_reg, fend_next;
    logic               chok_reg, chok_next;
    logic [CH_W-1:0]    idx_reg, idx_next;

    // Shared divider
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0] div_reg, div_next;

    // Frame and idle timer state
    logic               pend_valid_reg, pend_valid_next;
    logic [CHAN_W-1:0]  pend_chan_reg, pend_chan_next;
    logic [TIME_W-1:0]  last_touch_reg, last_touch_next;
    logic               ambient_reg, ambient_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               kind_reg, kind_next;
    logic               tvalid_reg, tvalid_next;
    logic [CHAN_W-1:0]  tchan_reg, tchan_next;
    logic               amb_out_reg, amb_out_next;

    // Array write controls
    logic               thr_we;
    logic [RAW_W-1:0]   thr_wdata;
    logic               above_we;
    logic               above_wdata;
    logic               trig_we;
    logic               cal_clr;
    logic               cal_we;

    // Combinational helpers
    logic               in_accept;
    logic               out_free;
    logic [RAW_W-1:0]   thr_rd;
    logic               above_rd;
    logic [TIME_W-1:0]  trig_rd;
    logic [SUM_W-1:0]   sum_rd;
    logic [COUNT_W-1:0] cnt_rd;
    logic               above_now;
    logic               touch;
    logic [TIME_W-1:0]  eff_touch;
    logic               eff_ambient;
    logic               idle_expired;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   trial_diff;
    logic               trial_ge;

    assign in_stall        = (state_reg != ST_IDLE);
    assign in_accept       = in_valid && !in_stall;
    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign trigger_valid   = tvalid_reg;
    assign trigger_channel = tchan_reg;
    assign enter_ambient   = amb_out_reg;

    // Output slot is free if empty or drained at this edge
    assign out_free = !out_valid_reg || !out_stall;

    // Single read port at the current channel index
    assign thr_rd   = thr_reg[idx_reg];
    assign above_rd = above_reg[idx_reg];
    assign trig_rd  = trig_reg[idx_reg];
    assign sum_rd   = sum_reg[idx_reg];
    assign cnt_rd   = cnt_reg[idx_reg];

    // Touch detection: rising crossing outside the debounce lockout
    assign above_now = raw_reg > thr_rd;
    assign touch     = above_now && !above_rd
                       && ((now_reg - trig_rd) >= {16'd0, debounce_time_reg});

    // Idle timer at frame end
    assign eff_touch    = pend_valid_reg ? now_reg : last_touch_reg;
    assign eff_ambient  = pend_valid_reg ? 1'b0 : ambient_reg;
    assign idle_expired = !eff_ambient && ((now_reg - eff_touch) >= idle_timeout_reg);

    // Restoring divider step: one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = trial >= {1'b0, div_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_offset_reg  <= TOUCH_OFFSET_RST;
            debounce_time_reg <= DEBOUNCE_TIME_RST;
            idle_timeout_reg  <= IDLE_TIMEOUT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TOUCH_OFFSET:  touch_offset_reg  <= cfg_data[RAW_W-1:0];
                REG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data[RAW_W-1:0];
                REG_IDLE_TIMEOUT:  idle_timeout_reg  <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-channel arrays
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                thr_reg[i]   <= '0;
                above_reg[i] <= 1'b0;
                trig_reg[i]  <= '0;
                sum_reg[i]   <= '0;
                cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            if (thr_we)
                thr_reg[idx_reg] <= thr_wdata;
            if (above_we)
                above_reg[idx_reg] <= above_wdata;
            if (trig_we)
                trig_reg[idx_reg] <= now_reg;
            if (cal_clr)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    sum_reg[i] <= '0;
                    cnt_reg[i] <= '0;
                end
            end
            else if (cal_we)
            begin
                sum_reg[idx_reg] <= sum_rd + {{(SUM_W-RAW_W){1'b0}}, raw_reg};
                cnt_reg[idx_reg] <= cnt_rd + COUNT_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            pend_chan_reg  <= '0;
            last_touch_reg <= '0;
            ambient_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            pend_chan_reg  <= pend_chan_next;
            last_touch_reg <= last_touch_next;
            ambient_reg    <= ambient_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        chan_reg    <= chan_next;
        raw_reg     <= raw_next;
        now_reg     <= now_next;
        fend_reg    <= fend_next;
        chok_reg    <= chok_next;
        idx_reg     <= idx_next;
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_reg     <= div_next;
        kind_reg    <= kind_next;
        tvalid_reg  <= tvalid_next;
        tchan_reg   <= tchan_next;
        amb_out_reg <= amb_out_next;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        chan_next       = chan_reg;
        raw_next        = raw_reg;
        now_next        = now_reg;
        fend_next       = fend_reg;
        chok_next       = chok_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_next        = div_reg;
        pend_valid_next = pend_valid_reg;
        pend_chan_next  = pend_chan_reg;
        last_touch_next = last_touch_reg;
        ambient_next    = ambient_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        tvalid_next     = tvalid_reg;
        tchan_next      = tchan_reg;
        amb_out_next    = amb_out_reg;
        thr_we          = 1'b0;
        thr_wdata       = raw_reg;
        above_we        = 1'b0;
        above_wdata     = above_now;
        trig_we         = 1'b0;
        cal_clr         = 1'b0;
        cal_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next   = opcode_t'(opcode);
                    chan_next = channel;
                    raw_next  = raw_value;
                    now_next  = now_ms;
                    fend_next = frame_end;
                    chok_next = (32'(channel) < 32'(CHANNELS));
                    if (opcode_t'(opcode) == OP_CAL_FINISH)
                    begin
                        idx_next   = '0;
                        state_next = ST_DIV_LOAD;
                    end
                    else
                    begin
                        idx_next   = CH_W'(channel);
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (op_reg)
                    OP_DETECT:
                    begin
                        if (chok_reg)
                        begin
                            above_we = 1'b1;
                            if (touch)
                            begin
                                trig_we         = 1'b1;
                                pend_valid_next = 1'b1;
                                pend_chan_next  = chan_reg;
                            end
                        end
                        if (fend_reg)
                            state_next = ST_FRAME;
                    end
                    OP_CAL_START:
                        cal_clr = 1'b1;
                    OP_CAL_SAMPLE:
                        cal_we = chok_reg && (cnt_rd < CAL_MAX);
                    OP_LOAD_THR:
                        thr_we = chok_reg;
                    default: ;
                endcase
            end

            ST_FRAME:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_FRAME;
                    tvalid_next     = pend_valid_reg;
                    tchan_next      = pend_valid_reg ? pend_chan_reg : '0;
                    amb_out_next    = idle_expired;
                    last_touch_next = eff_touch;
                    ambient_next    = eff_ambient || idle_expired;
                    pend_valid_next = 1'b0;
                    pend_chan_next  = '0;
                    state_next      = ST_IDLE;
                end
            end

            ST_DIV_LOAD:
            begin
                rem_next   = '0;
                quo_next   = sum_rd;
                div_next   = cnt_rd;
                step_next  = '0;
                state_next = ST_DIV_STEP;
            end

            ST_DIV_STEP:
            begin
                rem_next  = trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], trial_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST)
                    state_next = ST_DIV_STORE;
            end

            ST_DIV_STORE:
            begin
                // No samples gives a zero baseline
                thr_we    = 1'b1;
                thr_wdata = ((div_reg == '0) ? '0 : quo_reg[RAW_W-1:0]) + touch_offset_reg;
                if (idx_reg == LAST_CH)
                    state_next = ST_CAL_DONE;
                else
                begin
                    idx_next   = idx_reg + CH_W'(1);
                    state_next = ST_DIV_LOAD;
                end
            end

            ST_CAL_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_CAL_END;
                    tvalid_next     = 1'b0;
                    tchan_next      = '0;
                    amb_out_next    = 1'b0;
                    last_touch_next = now_reg;
                    ambient_next    = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### src/ttt_checker.sv
`default_nettype none

module ttt_checker
    import ttt_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic                  result_kind,
    input wire logic                  trigger_valid,
    input wire logic [CHAN_W-1:0]     trigger_channel,
    input wire logic                  enter_ambient
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_kind) && $stable(trigger_valid)
            && $stable(trigger_channel) && $stable(enter_ambient))
        else $error("result payload changed while stalled");

    // Block is busy in the cycle after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a transaction");

    // Calibration-finished results carry no trigger or ambient flag
    a_cal_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_CAL_END) |->
            !trigger_valid && !enter_ambient && (trigger_channel == '0))
        else $error("calibration result with trigger fields set");

    // No trigger reports channel zero
    a_no_trig_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !trigger_valid |-> (trigger_channel == '0))
        else $error("channel reported without a trigger");

endmodule

bind touch_threshold_trigger_top ttt_checker u_ttt_checker (.*);

`default_nettype wire
